>>> rtl/tlbfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfl_pkg: shared types and constants for the FIFO/LRU translation buffer
// Command codes, field widths, cell update and scan flag structs, FSM states.
// ----------------------------------------------------------------------------
package tlbfl_pkg;

  // default geometry
  localparam int ENTRIES_DEF    = 4;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int FRAME_BITS_DEF = 20;

  // fixed port field widths
  localparam int CMD_W         = 2;
  localparam int PAGE_FIELD_W  = 20;
  localparam int FRAME_FIELD_W = 20;
  localparam int SLOT_FIELD_W  = 2;
  localparam int TOTAL_W       = 32;

  // replacement policy register values
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FLUSH  = 2'd2
  } tlb_cmd_t;

  // broadcast update applied to every cell in the same cycle
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_FILL,
    UPD_TO_BACK,
    UPD_FLUSH
  } upd_op_t;

  typedef struct packed {
    upd_op_t op;
    logic    wr;    // target cell takes new page/frame
  } upd_ctl_t;

  // flags carried by the search token along the chain
  typedef struct packed {
    logic active;
    logic found;
    logic free_found;
    logic victim_found;
  } scan_flag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tlb_state_t;

endpackage

>>> rtl/tlbfl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfl_cell: one translation entry of the cell chain
// Holds valid, page, frame and replacement rank; folds itself into the
// passing search token and applies the broadcast update.
// ----------------------------------------------------------------------------
module tlbfl_cell import tlbfl_pkg::*; #(
  parameter int CELL_IDX   = 0,
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // search token in
  input  scan_flag_t            scan_flag_i,
  input  logic [PAGE_BITS-1:0]  scan_page_i,
  input  logic [IDX_W-1:0]      scan_hit_idx_i,
  input  logic [FRAME_BITS-1:0] scan_hit_frame_i,
  input  logic [IDX_W-1:0]      scan_hit_rank_i,
  input  logic [IDX_W-1:0]      scan_free_idx_i,
  input  logic [IDX_W-1:0]      scan_victim_idx_i,
  input  logic [CNT_W-1:0]      scan_vcount_i,
  // search token out (registered)
  output scan_flag_t            scan_flag_o,
  output logic [PAGE_BITS-1:0]  scan_page_o,
  output logic [IDX_W-1:0]      scan_hit_idx_o,
  output logic [FRAME_BITS-1:0] scan_hit_frame_o,
  output logic [IDX_W-1:0]      scan_hit_rank_o,
  output logic [IDX_W-1:0]      scan_free_idx_o,
  output logic [IDX_W-1:0]      scan_victim_idx_o,
  output logic [CNT_W-1:0]      scan_vcount_o,
  // broadcast update
  input  upd_ctl_t              upd_ctl_i,
  input  logic [IDX_W-1:0]      upd_idx_i,
  input  logic [IDX_W-1:0]      upd_rank_i,
  input  logic [IDX_W-1:0]      upd_last_i,
  input  logic [PAGE_BITS-1:0]  upd_page_i,
  input  logic [FRAME_BITS-1:0] upd_frame_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                  valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [IDX_W-1:0]      rank_r, rank_nxt;

  scan_flag_t            sflag_r, sflag_nxt;
  logic [PAGE_BITS-1:0]  spage_r, spage_nxt;
  logic [IDX_W-1:0]      shit_idx_r, shit_idx_nxt;
  logic [FRAME_BITS-1:0] shit_frame_r, shit_frame_nxt;
  logic [IDX_W-1:0]      shit_rank_r, shit_rank_nxt;
  logic [IDX_W-1:0]      sfree_idx_r, sfree_idx_nxt;
  logic [IDX_W-1:0]      svict_idx_r, svict_idx_nxt;
  logic [CNT_W-1:0]      svcount_r, svcount_nxt;

  logic is_tgt;
  logic match;
  logic is_front;

  assign is_tgt   = (upd_idx_i == MY_IDX);
  assign match    = valid_r && (page_r == scan_page_i);
  assign is_front = valid_r && (rank_r == '0);

  // entry update
  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    frame_nxt = frame_r;
    rank_nxt  = rank_r;
    unique case (upd_ctl_i.op)
      UPD_NONE: ;
      UPD_FLUSH: valid_nxt = 1'b0;
      UPD_FILL: begin
        if (is_tgt) begin
          valid_nxt = 1'b1;
          rank_nxt  = upd_last_i;
        end
      end
      UPD_TO_BACK: begin
        if (is_tgt) begin
          rank_nxt = upd_last_i;
        end else if (valid_r && (rank_r > upd_rank_i)) begin
          rank_nxt = rank_r - IDX_W'(1);
        end
      end
      default: ;
    endcase
    if (is_tgt && upd_ctl_i.wr) begin
      page_nxt  = upd_page_i;
      frame_nxt = upd_frame_i;
    end
  end

  // token fold: first match, first free, front of order, valid count
  always_comb begin
    sflag_nxt      = scan_flag_i;
    spage_nxt      = scan_page_i;
    shit_idx_nxt   = scan_hit_idx_i;
    shit_frame_nxt = scan_hit_frame_i;
    shit_rank_nxt  = scan_hit_rank_i;
    sfree_idx_nxt  = scan_free_idx_i;
    svict_idx_nxt  = scan_victim_idx_i;
    svcount_nxt    = scan_vcount_i + CNT_W'(valid_r);
    if (match && !scan_flag_i.found) begin
      sflag_nxt.found = 1'b1;
      shit_idx_nxt    = MY_IDX;
      shit_frame_nxt  = frame_r;
      shit_rank_nxt   = rank_r;
    end
    if (!valid_r && !scan_flag_i.free_found) begin
      sflag_nxt.free_found = 1'b1;
      sfree_idx_nxt        = MY_IDX;
    end
    if (is_front && !scan_flag_i.victim_found) begin
      sflag_nxt.victim_found = 1'b1;
      svict_idx_nxt          = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sflag_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      sflag_r <= sflag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    frame_r      <= frame_nxt;
    rank_r       <= rank_nxt;
    spage_r      <= spage_nxt;
    shit_idx_r   <= shit_idx_nxt;
    shit_frame_r <= shit_frame_nxt;
    shit_rank_r  <= shit_rank_nxt;
    sfree_idx_r  <= sfree_idx_nxt;
    svict_idx_r  <= svict_idx_nxt;
    svcount_r    <= svcount_nxt;
  end

  assign scan_flag_o       = sflag_r;
  assign scan_page_o       = spage_r;
  assign scan_hit_idx_o    = shit_idx_r;
  assign scan_hit_frame_o  = shit_frame_r;
  assign scan_hit_rank_o   = shit_rank_r;
  assign scan_free_idx_o   = sfree_idx_r;
  assign scan_victim_idx_o = svict_idx_r;
  assign scan_vcount_o     = svcount_r;

endmodule

>>> rtl/tlb_fifo_lru_replace_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replace_top: fully associative TLB with FIFO or LRU victim order
// Flow: one item at a time; a new item is accepted only once the last commits.
//   The search token walks the cell chain one entry per cycle, then the final
//   token is captured and the result is committed once the output is free.
// Reset: synchronous, active low; clears valid bits, totals, policy (FIFO)
//   and handshake state. Page/frame storage and ranks are not cleared.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_replace_top import tlbfl_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [PAGE_FIELD_W-1:0]  in_page,
  input  logic [FRAME_FIELD_W-1:0] in_frame,
  // result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic [FRAME_FIELD_W-1:0] out_frame_out,
  output logic [SLOT_FIELD_W-1:0]  out_slot,
  output logic                     out_replaced,
  output logic [TOTAL_W-1:0]       out_hit_count,
  output logic [TOTAL_W-1:0]       out_miss_count,
  output logic [TOTAL_W-1:0]       out_fill_count,
  output logic [TOTAL_W-1:0]       out_replace_count
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // The replacement order is kept as a rank per entry: rank 0 is the front
  // of the queue, rank (valid count - 1) the back. Valid entries always hold
  // distinct ranks, so the queue is exactly the set of valid entries.

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  tlb_state_t state_r, state_nxt;

  logic accept;
  logic fin_load;
  logic commit;
  logic out_free;
  logic out_valid_r, out_valid_nxt;

  assign out_free = !out_valid_r || !out_stall;

  logic policy_r, policy_nxt;

  // accepted item
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  seed_act_r, seed_act_nxt;

  // ---------------------------------------------------------------------
  // cell chain links: link 0 is the seed, link k+1 leaves cell k
  // ---------------------------------------------------------------------
  scan_flag_t            lk_flag      [ENTRIES+1];
  logic [PAGE_BITS-1:0]  lk_page      [ENTRIES+1];
  logic [IDX_W-1:0]      lk_hit_idx   [ENTRIES+1];
  logic [FRAME_BITS-1:0] lk_hit_frame [ENTRIES+1];
  logic [IDX_W-1:0]      lk_hit_rank  [ENTRIES+1];
  logic [IDX_W-1:0]      lk_free_idx  [ENTRIES+1];
  logic [IDX_W-1:0]      lk_vict_idx  [ENTRIES+1];
  logic [CNT_W-1:0]      lk_vcount    [ENTRIES+1];

  scan_flag_t seed_flag;

  always_comb begin
    seed_flag        = '0;
    seed_flag.active = seed_act_r;
  end

  assign lk_flag[0]      = seed_flag;
  assign lk_page[0]      = page_r;
  assign lk_hit_idx[0]   = '0;
  assign lk_hit_frame[0] = '0;
  assign lk_hit_rank[0]  = '0;
  assign lk_free_idx[0]  = '0;
  assign lk_vict_idx[0]  = '0;
  assign lk_vcount[0]    = '0;

  // broadcast update
  upd_ctl_t              upd_ctl;
  logic [IDX_W-1:0]      upd_idx;
  logic [IDX_W-1:0]      upd_rank;
  logic [IDX_W-1:0]      upd_last;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    tlbfl_cell #(
      .CELL_IDX   (k),
      .ENTRIES    (ENTRIES),
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
    ) u_cell (
      .clk               (clk),
      .rst_n             (rst_n),
      .scan_flag_i       (lk_flag[k]),
      .scan_page_i       (lk_page[k]),
      .scan_hit_idx_i    (lk_hit_idx[k]),
      .scan_hit_frame_i  (lk_hit_frame[k]),
      .scan_hit_rank_i   (lk_hit_rank[k]),
      .scan_free_idx_i   (lk_free_idx[k]),
      .scan_victim_idx_i (lk_vict_idx[k]),
      .scan_vcount_i     (lk_vcount[k]),
      .scan_flag_o       (lk_flag[k+1]),
      .scan_page_o       (lk_page[k+1]),
      .scan_hit_idx_o    (lk_hit_idx[k+1]),
      .scan_hit_frame_o  (lk_hit_frame[k+1]),
      .scan_hit_rank_o   (lk_hit_rank[k+1]),
      .scan_free_idx_o   (lk_free_idx[k+1]),
      .scan_victim_idx_o (lk_vict_idx[k+1]),
      .scan_vcount_o     (lk_vcount[k+1]),
      .upd_ctl_i         (upd_ctl),
      .upd_idx_i         (upd_idx),
      .upd_rank_i        (upd_rank),
      .upd_last_i        (upd_last),
      .upd_page_i        (page_r),
      .upd_frame_i       (frame_r)
    );
  end

  // ---------------------------------------------------------------------
  // FSM
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (lk_flag[ENTRIES].active) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    fin_load = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_SCAN: fin_load = lk_flag[ENTRIES].active;
      ST_DONE: commit   = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // item capture and token seed
  // ---------------------------------------------------------------------
  always_comb begin
    policy_nxt   = cfg_wr_en ? cfg_wr_data : policy_r;
    cmd_nxt      = accept ? in_cmd : cmd_r;
    page_nxt     = accept ? PAGE_BITS'(in_page) : page_r;
    frame_nxt    = accept ? FRAME_BITS'(in_frame) : frame_r;
    seed_act_nxt = accept;
  end

  // final token snapshot (the chain only shows it for one cycle)
  scan_flag_t            fin_flag_r, fin_flag_nxt;
  logic [IDX_W-1:0]      fin_hit_idx_r, fin_hit_idx_nxt;
  logic [FRAME_BITS-1:0] fin_hit_frame_r, fin_hit_frame_nxt;
  logic [IDX_W-1:0]      fin_hit_rank_r, fin_hit_rank_nxt;
  logic [IDX_W-1:0]      fin_free_idx_r, fin_free_idx_nxt;
  logic [IDX_W-1:0]      fin_vict_idx_r, fin_vict_idx_nxt;
  logic [CNT_W-1:0]      fin_vcount_r, fin_vcount_nxt;

  always_comb begin
    fin_flag_nxt      = fin_flag_r;
    fin_hit_idx_nxt   = fin_hit_idx_r;
    fin_hit_frame_nxt = fin_hit_frame_r;
    fin_hit_rank_nxt  = fin_hit_rank_r;
    fin_free_idx_nxt  = fin_free_idx_r;
    fin_vict_idx_nxt  = fin_vict_idx_r;
    fin_vcount_nxt    = fin_vcount_r;
    if (fin_load) begin
      fin_flag_nxt      = lk_flag[ENTRIES];
      fin_hit_idx_nxt   = lk_hit_idx[ENTRIES];
      fin_hit_frame_nxt = lk_hit_frame[ENTRIES];
      fin_hit_rank_nxt  = lk_hit_rank[ENTRIES];
      fin_free_idx_nxt  = lk_free_idx[ENTRIES];
      fin_vict_idx_nxt  = lk_vict_idx[ENTRIES];
      fin_vcount_nxt    = lk_vcount[ENTRIES];
    end
  end

  // ---------------------------------------------------------------------
  // result and entry update
  // ---------------------------------------------------------------------
  logic                  res_hit;
  logic [FRAME_BITS-1:0] res_frame;
  logic [IDX_W-1:0]      res_slot;
  logic                  res_repl;
  logic                  inc_hit, inc_miss, inc_fill, inc_repl;
  upd_ctl_t              upd_ctl_c;

  logic [TOTAL_W-1:0] hit_tot_r, hit_tot_nxt;
  logic [TOTAL_W-1:0] miss_tot_r, miss_tot_nxt;
  logic [TOTAL_W-1:0] fill_tot_r, fill_tot_nxt;
  logic [TOTAL_W-1:0] repl_tot_r, repl_tot_nxt;

  always_comb begin
    res_hit   = 1'b0;
    res_frame = '0;
    res_slot  = '0;
    res_repl  = 1'b0;
    inc_hit   = 1'b0;
    inc_miss  = 1'b0;
    inc_fill  = 1'b0;
    inc_repl  = 1'b0;
    upd_ctl_c = '{op: UPD_NONE, wr: 1'b0};
    upd_idx   = '0;
    upd_rank  = '0;
    upd_last  = '0;
    unique case (cmd_r)
      CMD_LOOKUP: begin
        if (fin_flag_r.found) begin
          res_hit   = 1'b1;
          res_frame = fin_hit_frame_r;
          res_slot  = fin_hit_idx_r;
          inc_hit   = 1'b1;
          // LRU: hit entry goes to the back of the order
          if (policy_r == POLICY_LRU) begin
            upd_ctl_c = '{op: UPD_TO_BACK, wr: 1'b0};
            upd_idx   = fin_hit_idx_r;
            upd_rank  = fin_hit_rank_r;
            upd_last  = IDX_W'(fin_vcount_r - CNT_W'(1));
          end
        end else begin
          inc_miss = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (fin_flag_r.free_found) begin
          // lowest free entry, appended at the back
          res_slot  = fin_free_idx_r;
          inc_fill  = 1'b1;
          upd_ctl_c = '{op: UPD_FILL, wr: 1'b1};
          upd_idx   = fin_free_idx_r;
          upd_last  = IDX_W'(fin_vcount_r);
        end else if (fin_flag_r.victim_found) begin
          // evict the front entry and requeue it at the back
          res_slot  = fin_vict_idx_r;
          res_repl  = 1'b1;
          inc_repl  = 1'b1;
          upd_ctl_c = '{op: UPD_TO_BACK, wr: 1'b1};
          upd_idx   = fin_vict_idx_r;
          upd_rank  = '0;
          upd_last  = IDX_W'(fin_vcount_r - CNT_W'(1));
        end
      end
      CMD_FLUSH: upd_ctl_c = '{op: UPD_FLUSH, wr: 1'b0};
      default: ;
    endcase
  end

  // nothing touches the cells except on the commit cycle
  assign upd_ctl = commit ? upd_ctl_c : upd_ctl_t'{op: UPD_NONE, wr: 1'b0};

  always_comb begin
    hit_tot_nxt  = hit_tot_r  + TOTAL_W'(commit && inc_hit);
    miss_tot_nxt = miss_tot_r + TOTAL_W'(commit && inc_miss);
    fill_tot_nxt = fill_tot_r + TOTAL_W'(commit && inc_fill);
    repl_tot_nxt = repl_tot_r + TOTAL_W'(commit && inc_repl);
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  logic                     out_hit_r;
  logic [FRAME_FIELD_W-1:0] out_frame_r;
  logic [SLOT_FIELD_W-1:0]  out_slot_r;
  logic                     out_repl_r;
  logic [TOTAL_W-1:0]       out_hit_cnt_r, out_miss_cnt_r, out_fill_cnt_r, out_repl_cnt_r;

  assign out_valid_nxt = commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= POLICY_FIFO;
      seed_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_tot_r   <= '0;
      miss_tot_r  <= '0;
      fill_tot_r  <= '0;
      repl_tot_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      seed_act_r  <= seed_act_nxt;
      out_valid_r <= out_valid_nxt;
      hit_tot_r   <= hit_tot_nxt;
      miss_tot_r  <= miss_tot_nxt;
      fill_tot_r  <= fill_tot_nxt;
      repl_tot_r  <= repl_tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    page_r          <= page_nxt;
    frame_r         <= frame_nxt;
    fin_flag_r      <= fin_flag_nxt;
    fin_hit_idx_r   <= fin_hit_idx_nxt;
    fin_hit_frame_r <= fin_hit_frame_nxt;
    fin_hit_rank_r  <= fin_hit_rank_nxt;
    fin_free_idx_r  <= fin_free_idx_nxt;
    fin_vict_idx_r  <= fin_vict_idx_nxt;
    fin_vcount_r    <= fin_vcount_nxt;
    if (commit) begin
      out_hit_r      <= res_hit;
      out_frame_r    <= FRAME_FIELD_W'(res_frame);
      out_slot_r     <= SLOT_FIELD_W'(res_slot);
      out_repl_r     <= res_repl;
      out_hit_cnt_r  <= hit_tot_nxt;
      out_miss_cnt_r <= miss_tot_nxt;
      out_fill_cnt_r <= fill_tot_nxt;
      out_repl_cnt_r <= repl_tot_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_out     = out_frame_r;
  assign out_slot          = out_slot_r;
  assign out_replaced      = out_repl_r;
  assign out_hit_count     = out_hit_cnt_r;
  assign out_miss_count    = out_miss_cnt_r;
  assign out_fill_count    = out_fill_cnt_r;
  assign out_replace_count = out_repl_cnt_r;

endmodule

>>> tb/tlb_fifo_lru_replace_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replace_top_tb: self-checking bench for the FIFO/LRU TLB
// A queue-fed driver sends lookup, insert, flush and unused commands in bursts
// with random gaps. Each accepted item runs through a behavioral translation
// buffer kept in the bench. A monitor with its own stall pattern compares every
// result in order against the predicted one. Directed items cover fills, the
// lowest-match rule, duplicate inserts, eviction order under both policies,
// flush and the unused command. Random phases alternate the policy.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_replace_top_tb;
  import tlbfl_pkg::*;

  localparam int N_ENTRIES   = ENTRIES_DEF;
  localparam int DRAIN_CYC   = N_ENTRIES + 3;      // one item's trip through the block
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_MAX   = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;  // no operation defined

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [PAGE_FIELD_W-1:0]  page;
    logic [FRAME_FIELD_W-1:0] frame;
  } xlat_req_t;

  typedef struct packed {
    logic                     hit;
    logic [FRAME_FIELD_W-1:0] frame_out;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic                     replaced;
    logic [TOTAL_W-1:0]       hits;
    logic [TOTAL_W-1:0]       misses;
    logic [TOTAL_W-1:0]       fills;
    logic [TOTAL_W-1:0]       replaces;
  } xlat_resp_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [PAGE_FIELD_W-1:0] in_page = '0;
  logic [FRAME_FIELD_W-1:0] in_frame = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [FRAME_FIELD_W-1:0] out_frame_out;
  logic [SLOT_FIELD_W-1:0] out_slot;
  logic out_replaced;
  logic [TOTAL_W-1:0] out_hit_count;
  logic [TOTAL_W-1:0] out_miss_count;
  logic [TOTAL_W-1:0] out_fill_count;
  logic [TOTAL_W-1:0] out_replace_count;

  tlb_fifo_lru_replace_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_page           (in_page),
    .in_frame          (in_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_out     (out_frame_out),
    .out_slot          (out_slot),
    .out_replaced      (out_replaced),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count),
    .out_fill_count    (out_fill_count),
    .out_replace_count (out_replace_count)
  );

  // Bench copy of the translation buffer. Page/frame contents are only read
  // while the entry is valid, so leaving them at zero is harmless.
  logic                     shadow_policy = POLICY_FIFO;
  logic                     shadow_valid [N_ENTRIES] = '{default: 1'b0};
  logic [PAGE_FIELD_W-1:0]  shadow_page  [N_ENTRIES] = '{default: '0};
  logic [FRAME_FIELD_W-1:0] shadow_frame [N_ENTRIES] = '{default: '0};
  logic [SLOT_FIELD_W-1:0]  victim_order[$];          // front is next victim
  logic [TOTAL_W-1:0] hit_total = '0;
  logic [TOTAL_W-1:0] miss_total = '0;
  logic [TOTAL_W-1:0] fill_total = '0;
  logic [TOTAL_W-1:0] replace_total = '0;

  xlat_req_t  pending_items[$];      // filled by the stimulus, drained by the driver
  xlat_resp_t translations_due[$];   // predicted results, oldest first
  int mismatches = 0;
  int cycle_count = 0;

  // Applies one command to the bench copy and returns the result it predicts.
  function automatic xlat_resp_t predict_translation(input xlat_req_t req);
    xlat_resp_t r;
    bit done;
    logic [SLOT_FIELD_W-1:0] v;
    r = '0;
    done = 1'b0;
    case (req.cmd)
      CMD_LOOKUP: begin
        // lowest matching index wins when a page sits in several entries
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (!done && shadow_valid[i] && shadow_page[i] == req.page) begin
            done = 1'b1;
            r.hit = 1'b1;
            r.frame_out = shadow_frame[i];
            r.slot = SLOT_FIELD_W'(i);
            if (shadow_policy == POLICY_LRU) begin
              // the hit entry goes to the back of the victim order
              for (int k = 0; k < victim_order.size(); k++) begin
                if (victim_order[k] == SLOT_FIELD_W'(i)) begin
                  victim_order.delete(k);
                  victim_order.push_back(SLOT_FIELD_W'(i));
                  break;
                end
              end
            end
          end
        end
        if (done) hit_total++;
        else miss_total++;
      end
      CMD_INSERT: begin
        // no duplicate check: always a free entry or the front victim
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (!done && !shadow_valid[i]) begin
            done = 1'b1;
            shadow_valid[i] = 1'b1;
            shadow_page[i] = req.page;
            shadow_frame[i] = req.frame;
            victim_order.push_back(SLOT_FIELD_W'(i));
            fill_total++;
            r.slot = SLOT_FIELD_W'(i);
          end
        end
        if (!done && victim_order.size() > 0) begin
          v = victim_order.pop_front();
          shadow_page[v] = req.page;
          shadow_frame[v] = req.frame;
          victim_order.push_back(v);
          replace_total++;
          r.replaced = 1'b1;
          r.slot = v;
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < N_ENTRIES; i++) shadow_valid[i] = 1'b0;
        victim_order.delete();
      end
      default: ;  // unused command: state untouched
    endcase
    r.hits = hit_total;
    r.misses = miss_total;
    r.fills = fill_total;
    r.replaces = replace_total;
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: bursts of random length separated by random gaps. Prediction runs
  // at the edge that accepts the item, from what is on the wires.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    xlat_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        translations_due.push_back(predict_translation({in_cmd, in_page, in_frame}));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          in_cmd <= nxt.cmd;
          in_page <= nxt.page;
          in_frame <= nxt.frame;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stall pattern switches mode every so often; each
  // accepted result is checked against the oldest prediction.
  rx_mode_t rx_mode = RX_FREE;
  int rx_mode_left = 0;

  always @(posedge clk) begin
    xlat_resp_t got;
    xlat_resp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_hit, out_frame_out, out_slot, out_replaced,
               out_hit_count, out_miss_count, out_fill_count, out_replace_count};
        if (translations_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: result with nothing outstanding: hit=%0b frame=%h slot=%0d",
                     $realtime, got.hit, got.frame_out, got.slot);
        end else begin
          want = translations_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX) begin
              $display("%0t: mismatch exp hit=%0b frame=%h slot=%0d repl=%0b cnt=%0d/%0d/%0d/%0d",
                       $realtime, want.hit, want.frame_out, want.slot, want.replaced,
                       want.hits, want.misses, want.fills, want.replaces);
              $display("             got hit=%0b frame=%h slot=%0d repl=%0b cnt=%0d/%0d/%0d/%0d",
                       got.hit, got.frame_out, got.slot, got.replaced,
                       got.hits, got.misses, got.fills, got.replaces);
            end
          end
        end
      end
      if (rx_mode_left <= 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
        RX_PERIODIC: out_stall <= ((cycle_count % 5) < 2);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, translations_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] cmd,
                            input logic [PAGE_FIELD_W-1:0] page,
                            input logic [FRAME_FIELD_W-1:0] frame);
    pending_items.push_back('{cmd: cmd, page: page, frame: frame});
  endtask

  // Wait until every item went in and every result came back, then let the
  // block settle before touching the policy register. Sampled at the falling
  // edge so the driver's updates from the rising edge have landed.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || translations_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_policy(input logic pol);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_policy = pol;
  endtask

  // Random phase: mostly a small page pool so inserts collide and lookups hit,
  // plus some fully random pages, flushes and unused commands as noise.
  task automatic random_phase(input int n);
    logic [PAGE_FIELD_W-1:0] pool [6];
    logic [PAGE_FIELD_W-1:0] pg;
    logic [CMD_W-1:0] cmd;
    int roll;
    foreach (pool[i]) pool[i] = PAGE_FIELD_W'($urandom);
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) cmd = CMD_LOOKUP;
      else if (roll < 92) cmd = CMD_INSERT;
      else if (roll < 97) cmd = CMD_FLUSH;
      else cmd = CMD_UNUSED;
      pg = ($urandom_range(0, 9) == 0) ? PAGE_FIELD_W'($urandom)
                                        : pool[$urandom_range(0, 5)];
      queue_item(cmd, pg, FRAME_FIELD_W'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // FIFO, directed: fills, duplicate page, lowest match, eviction, flush
    set_policy(POLICY_FIFO);
    queue_item(CMD_LOOKUP, 20'h00000, 20'hFFFFF);   // empty buffer misses
    queue_item(CMD_INSERT, 20'hFFFFF, 20'h00000);
    queue_item(CMD_INSERT, 20'h00000, 20'hFFFFF);
    queue_item(CMD_INSERT, 20'h5A5A5, 20'hA5A5A);
    queue_item(CMD_INSERT, 20'hFFFFF, 20'h12345);   // same page again, entry 3
    queue_item(CMD_LOOKUP, 20'hFFFFF, 20'h00000);   // entry 0 wins
    queue_item(CMD_LOOKUP, 20'h00000, 20'h00000);
    queue_item(CMD_INSERT, 20'h11111, 20'h22222);   // full: evicts oldest fill
    queue_item(CMD_LOOKUP, 20'hFFFFF, 20'h00000);   // now only entry 3 holds it
    queue_item(CMD_UNUSED, 20'hFFFFF, 20'hFFFFF);
    queue_item(CMD_FLUSH, 20'hFFFFF, 20'hFFFFF);
    queue_item(CMD_LOOKUP, 20'h00000, 20'h00000);
    queue_item(CMD_INSERT, 20'hABCDE, 20'h54321);   // order restarts after flush
    wait_drained();

    // LRU, directed: a hit protects its entry from the next eviction
    set_policy(POLICY_LRU);
    queue_item(CMD_INSERT, 20'h00A00, 20'h0000A);
    queue_item(CMD_INSERT, 20'h00B00, 20'h0000B);
    queue_item(CMD_INSERT, 20'h00C00, 20'h0000C);
    queue_item(CMD_LOOKUP, 20'hABCDE, 20'h00000);   // oldest refreshed
    queue_item(CMD_INSERT, 20'h00D00, 20'h0000D);   // evicts the A page
    queue_item(CMD_LOOKUP, 20'hABCDE, 20'h00000);
    queue_item(CMD_LOOKUP, 20'h00A00, 20'h00000);
    queue_item(CMD_INSERT, 20'h00E00, 20'h0000E);
    queue_item(CMD_FLUSH, 20'h00000, 20'h00000);
    queue_item(CMD_INSERT, 20'h00F00, 20'h0000F);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      set_policy((ph % 2 == 0) ? POLICY_FIFO : POLICY_LRU);
      random_phase(92);
      wait_drained();
    end

    repeat (4 * DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && translations_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
